FILE: hdl/crcws_pkg.sv
// Shared constants, types and the CRC-32/MPEG-2 fold matrix.
`default_nettype none

package crcws_pkg;

	localparam int unsigned CRC_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PART_W = 24;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_TOPBIT = 32'h8000_0000;

	typedef logic [CRC_W-1:0] crc_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PART_W-1:0] part_t;
	typedef logic [1:0] bcount_t;
	typedef crc_t fold_cols_t [CRC_W];

	// 32 MSB-first polynomial steps; elaboration time only
	function automatic crc_t crc_steps(input crc_t v);
		crc_t c;
		c = v;
		for (int k = 0; k < CRC_W; k++) begin
			if ((c & CRC_TOPBIT) != '0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	// column i: image of a single set bit i under the 32-step fold
	function automatic fold_cols_t make_fold_cols();
		fold_cols_t cols;
		for (int i = 0; i < CRC_W; i++) begin
			cols[i] = crc_steps(crc_t'(1) << i);
		end
		return cols;
	endfunction

	localparam fold_cols_t FOLD_COLS = make_fold_cols();

endpackage

`default_nettype wire

FILE: hdl/crcws_ifs.sv
// Stream interfaces for message bytes in and CRC results out.
`default_nettype none

interface crcws_in_if;
	import crcws_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  has_byte;
	logic  last;
	modport source (output valid, output data_byte, output has_byte, output last, input ready);
	modport sink (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

interface crcws_out_if;
	import crcws_pkg::*;
	logic valid;
	logic ready;
	crc_t crc_value;
	modport source (output valid, output crc_value, input ready);
	modport sink (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/crcws_fold.sv
// XOR network: CRC xor word, advanced by 32 polynomial steps.
`default_nettype none

module crcws_fold (
	input  crcws_pkg::crc_t crc_in,
	input  crcws_pkg::crc_t word,
	output crcws_pkg::crc_t crc_out
);
	import crcws_pkg::*;

	crc_t x;

	assign x = crc_in ^ word;

	always_comb begin
		crc_out = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (x[i]) begin
				crc_out = crc_out ^ FOLD_COLS[i];
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/crc32_word_stream_core.sv
// CRC-32/MPEG-2 over a byte stream, folded one 32-bit word at a time.
// Result path: the item with last set is registered in stage 1; the result register then
//   takes the CRC unless an earlier result is still waiting for its transfer.
// Throughput: one item per cycle, but stalled while a last item waits behind that earlier result;
//   the single XOR fold network sets the clock path.
// Reset: arst_n clears the pipeline valids, CRC to all ones, partial word and count to zero.
`default_nettype none

module crc32_word_stream_core (
	input  logic           clk,
	input  logic           arst_n,
	crcws_in_if.sink       item,
	crcws_out_if.source    result
);
	import crcws_pkg::*;

	logic    valid_s1;
	byte_t   data_s1;
	logic    has_s1;
	logic    last_s1;

	crc_t    crc_q;
	part_t   partial_q;
	bcount_t count_q;

	logic    out_valid_q;
	crc_t    crc_value_q;

	logic    consume;
	logic    full;
	logic    fold_en;
	part_t   sel_partial;
	bcount_t sel_cnt;
	crc_t    word;
	crc_t    fold_out;
	crc_t    crc_next;

	assign consume    = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			data_s1 <= item.data_byte;
			has_s1  <= item.has_byte;
			last_s1 <= item.last;
		end
	end

	assign full        = has_s1 && (count_q == 2'd3);
	assign sel_partial = has_s1 ? {partial_q[15:0], data_s1} : partial_q;
	assign sel_cnt     = has_s1 ? count_q + 2'd1 : count_q;
	assign fold_en     = full || (last_s1 && (sel_cnt != 2'd0));

	always_comb begin
		if (full) begin
			word = {partial_q, data_s1};
		end else begin
			case (sel_cnt)
				2'd1:    word = {sel_partial[7:0], 24'h0};
				2'd2:    word = {sel_partial[15:0], 16'h0};
				default: word = {sel_partial, 8'h0};
			endcase
		end
	end

	crcws_fold u_fold (
		.crc_in  (crc_q),
		.word    (word),
		.crc_out (fold_out)
	);

	assign crc_next = fold_en ? fold_out : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			partial_q <= '0;
			count_q   <= '0;
		end else if (consume) begin
			if (last_s1) begin
				crc_q     <= CRC_INIT;
				partial_q <= '0;
				count_q   <= '0;
			end else begin
				crc_q     <= crc_next;
				partial_q <= full ? '0 : sel_partial;
				count_q   <= sel_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			crc_value_q <= crc_next;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.crc_value = crc_value_q;

endmodule

`default_nettype wire

FILE: hdl/crcws_checker.sv
// Port-level checks for the CRC stream core, bound into crc32_word_stream_core.
`default_nettype none

module crcws_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input crcws_pkg::crc_t crc_value
);

	// result held until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(crc_value))
		else $error("result changed while stalled");

	// input backpressure only comes from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// a new result needs an item taken or held in the stage register
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 2))
		else $error("result without a preceding item");

endmodule

bind crc32_word_stream_core crcws_checker u_crcws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.crc_value (result.crc_value)
);

`default_nettype wire

FILE: bench/crc32_word_stream_core_tb.sv
// Self-checking bench for crc32_word_stream_core: byte messages in, CRC-32/MPEG-2 words out.
module crc32_word_stream_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import crcws_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	crcws_in_if  in_if ();
	crcws_out_if out_if ();

	crc32_word_stream_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_if),
		.result (out_if)
	);

	// running CRC of the message in flight, as the block should hold it
	crc_t    run_crc;
	part_t   held_bytes;
	bcount_t held_cnt;
	crc_t    expected_crcs[$];
	crc_t    want_crc;

	int err_count;
	int mismatch_count;
	int item_count;
	int msg_count;
	int crc_checked;
	int quiet_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int holdoff_req;
	int holdoff_left;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic crc_t fold32(input crc_t crc, input crc_t word);
		crc_t r;
		r = crc ^ word;
		for (int k = 0; k < CRC_W; k++) begin
			if (r[CRC_W-1]) begin
				r = (r << 1) ^ CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("%0t ERROR: %s", $realtime, msg);
		end
	endfunction

	task automatic track_item(input byte_t b, input logic hb, input logic lst);
		if (hb) begin
			if (held_cnt == 2'd3) begin
				run_crc = fold32(run_crc, {held_bytes, b});
				held_bytes = '0;
				held_cnt = '0;
			end else begin
				held_bytes = {held_bytes[PART_W-BYTE_W-1:0], b};
				held_cnt = held_cnt + 2'd1;
			end
		end
		if (lst) begin
			// zero-pad the trailing partial word at its low end
			if (held_cnt != 2'd0) begin
				run_crc = fold32(run_crc, crc_t'({held_bytes, 8'h00}) << (8 * (3 - held_cnt)));
			end
			expected_crcs.push_back(run_crc);
			run_crc = CRC_INIT;
			held_bytes = '0;
			held_cnt = '0;
			msg_count++;
		end
		if (hb || lst) begin
			item_count++;
		end
	endtask

	// one transfer on the input channel; valid stays high afterwards
	task automatic send_item(input byte_t b, input logic hb, input logic lst);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid = 1'b0;
			in_if.data_byte = byte_t'($urandom);
			@(negedge clk);
		end
		in_if.valid = 1'b1;
		in_if.data_byte = b;
		in_if.has_byte = hb;
		in_if.last = lst;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		track_item(b, hb, lst);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_if.valid = 1'b0;
	endtask

	task automatic send_message(input int len, input bit sep_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8) begin
				send_item(byte_t'($urandom), 1'b0, 1'b0);
			end
			send_item(byte_t'($urandom), 1'b1, (i == len - 1) && !sep_end);
		end
		if (len == 0 || sep_end) begin
			send_item(byte_t'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic wait_drained();
		end_burst();
		while (expected_crcs.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_message();
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_check_string();
		string s;
		s = "123456789";
		for (int i = 0; i < s.len(); i++) begin
			send_item(byte_t'(s[i]), 1'b1, i == s.len() - 1);
		end
	endtask

	task automatic test_tail_lengths();
		// aligned: four bytes, then a terminator with no byte
		for (int i = 0; i < 4; i++) begin
			send_item(8'hFF, 1'b1, 1'b0);
		end
		send_item(8'hFF, 1'b0, 1'b1);
		// three bytes, with an ignored item in the middle
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b1);
		// two bytes, one byte
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFE, 1'b1, 1'b1);
		send_item(8'h7F, 1'b1, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_stream(input int sidle, input int ridle, input int budget);
		int start;
		int r;
		int len;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		start = item_count;
		while (item_count - start < budget) begin
			r = $urandom_range(99);
			if (r < 70) begin
				len = $urandom_range(9, 0);
			end else if (r < 95) begin
				len = $urandom_range(24, 10);
			end else begin
				len = $urandom_range(64, 25);
			end
			send_message(len, $urandom_range(3) == 0);
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holdoff_req = HOLDOFF_CYCLES;
		for (int i = 0; i < 40; i++) begin
			send_message($urandom_range(2, 0), 1'b0);
		end
		wait_drained();
	endtask

	// sink side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (holdoff_req > 0) begin
			holdoff_left = holdoff_req;
			holdoff_req = 0;
		end
		if (holdoff_left > 0) begin
			out_if.ready = 1'b0;
			holdoff_left--;
		end else begin
			out_if.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			if (expected_crcs.size() == 0) begin
				note_error($sformatf("crc_value %h with no message pending", out_if.crc_value));
			end else begin
				want_crc = expected_crcs.pop_front();
				crc_checked++;
				if (out_if.crc_value !== want_crc) begin
					mismatch_count++;
					note_error($sformatf("crc_value expected %h got %h",
						want_crc, out_if.crc_value));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
			(out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_crcs.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data_byte = '0;
		in_if.has_byte = 1'b0;
		in_if.last = 1'b0;
		out_if.ready = 1'b0;
		run_crc = CRC_INIT;
		held_bytes = '0;
		held_cnt = '0;
		err_count = 0;
		mismatch_count = 0;
		item_count = 0;
		msg_count = 0;
		crc_checked = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holdoff_req = 0;
		holdoff_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_check_string();
		test_tail_lengths();
		test_random_stream(36, 47, 500);
		test_random_stream(47, 36, 500);
		test_output_backpressure();
		test_random_stream(0, 0, 500);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run: %0d messages, %0d items, %0d CRCs checked, %0d mismatches",
			msg_count, item_count, crc_checked, mismatch_count);
		$display("Idle patterns 36/47, 47/36, none; one %0d-cycle output hold-off",
			HOLDOFF_CYCLES);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
